/* hdl/assert_macros.svh */
// Assertion macros used by the checker file; clk and rst_n come from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ffgc_pkg.sv */
// Shared constants and codes for the first-fit graph coloring block.
package ffgc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = 6;
    localparam int COLOR_W      = 7;
    localparam int MAX_COLOR    = MAX_VERTICES;
    localparam int IDX_W        = COLOR_W;

    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_COLOR    = 1'b1;

endpackage

/* hdl/first_fit_graph_coloring.sv */
// First-fit graph coloring engine: adjacency memory, color memory and scan sequencer.
//
// The block keeps a conflict graph of MAX_VERTICES vertices as a 64x64-bit
// adjacency memory plus a 7-bit color per vertex. An add-edge transfer
// (func = FUNC_ADD_EDGE) sets both symmetric bits with two read-modify-write
// row updates; a self-edge or an out-of-range vertex is dropped in the
// transfer cycle itself. A color transfer (func = FUNC_COLOR) reads the
// vertex's adjacency row, then walks the color memory one vertex entry per
// cycle through its single read port, marking the colors held by neighbors
// in a used-color vector, and finally steps a shared counter from color 1
// upward until a free color turns up. Item ready is high only while the
// sequencer is idle; a finished result sits in the output register until
// taken, and the next item may be accepted meanwhile. Reset needs no
// clearing pass: each adjacency row and each color entry carries a valid
// flop, and an entry not yet written reads as zero.
module first_fit_graph_coloring
    import ffgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_ready,
    input  logic               func,
    input  logic [VERT_W-1:0]  vertex_a,
    input  logic [VERT_W-1:0]  vertex_b,

    output logic               result_valid,
    input  logic               result_ready,
    output logic [VERT_W-1:0]  vertex,
    output logic [COLOR_W-1:0] color
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } state_t;

    // Sequencer state and item registers.
    state_t               state_reg, state_next;
    logic [VERT_W-1:0]    a_reg, a_next;
    logic [VERT_W-1:0]    b_reg, b_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [VERT_W-1:0]    idx_d_reg, idx_d_next;
    logic                 pend_reg, pend_next;
    logic [MAX_COLOR:0]   used_reg, used_next;
    logic                 rvalid_reg, rvalid_next;
    logic [VERT_W-1:0]    rvertex_reg, rvertex_next;
    logic [COLOR_W-1:0]   rcolor_reg, rcolor_next;

    // Adjacency memory: one row per vertex, row valid flags reset to zero.
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_row_vld_reg;
    logic [MAX_VERTICES-1:0] adj_rd_reg;
    logic                    adj_rd_vld_reg;
    logic [VERT_W-1:0]       adj_raddr;
    logic                    adj_we;
    logic [VERT_W-1:0]       adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_row;

    // Color memory: one color per vertex, entry valid flags reset to zero.
    logic [COLOR_W-1:0]      col_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] col_vld_reg;
    logic [COLOR_W-1:0]      col_rd_reg;
    logic                    col_rd_vld_reg;
    logic [VERT_W-1:0]       col_raddr;
    logic                    col_we;
    logic [COLOR_W-1:0]      held;

    logic                    accept;
    logic                    pick_done;

    function automatic logic in_graph(input logic [VERT_W-1:0] v);
        return int'(v) < MAX_VERTICES;
    endfunction

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = rvalid_reg;
    assign vertex       = rvertex_reg;
    assign color        = rcolor_reg;

    // Unwritten entries read as zero.
    assign adj_row = adj_rd_vld_reg ? adj_rd_reg : '0;
    assign held    = col_rd_vld_reg ? col_rd_reg : '0;

    // Free color found, or the top color reached; output register must be free.
    assign pick_done = (!used_reg[idx_reg] || (int'(idx_reg) == MAX_COLOR))
                       && (!rvalid_reg || result_ready);

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        idx_d_next   = idx_d_reg;
        pend_next    = 1'b0;
        used_next    = used_reg;
        rvalid_next  = rvalid_reg;
        rvertex_next = rvertex_reg;
        rcolor_next  = rcolor_reg;
        adj_raddr    = a_reg;
        adj_we       = 1'b0;
        adj_waddr    = a_reg;
        adj_wdata    = adj_row;
        col_raddr    = idx_reg[VERT_W-1:0];
        col_we       = 1'b0;

        if (rvalid_reg && result_ready)
        begin
            rvalid_next = 1'b0;
        end

        // Mark the color of the neighbor whose read was issued last cycle.
        if (pend_reg && adj_row[idx_d_reg] && (held != '0))
        begin
            used_next[held] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                adj_raddr = vertex_a;
                if (accept)
                begin
                    a_next = vertex_a;
                    b_next = vertex_b;
                    if (func == FUNC_COLOR)
                    begin
                        if (in_graph(vertex_a))
                        begin
                            idx_next   = '0;
                            used_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if ((vertex_a != vertex_b) && in_graph(vertex_a)
                             && in_graph(vertex_b))
                    begin
                        state_next = ST_EDGE_A;
                    end
                end
            end

            ST_EDGE_A:
            begin
                // Row a is in adj_row; set bit b and fetch row b.
                adj_we    = 1'b1;
                adj_waddr = a_reg;
                adj_wdata = adj_row | (MAX_VERTICES'(1) << b_reg);
                adj_raddr = b_reg;
                state_next = ST_EDGE_B;
            end

            ST_EDGE_B:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = adj_row | (MAX_VERTICES'(1) << a_reg);
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // Issue one color read per cycle; hold row a on the adjacency port.
                pend_next  = 1'b1;
                idx_d_next = idx_reg[VERT_W-1:0];
                if (int'(idx_reg) == MAX_VERTICES - 1)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_DRAIN:
            begin
                idx_next   = IDX_W'(1);
                state_next = ST_PICK;
            end

            ST_PICK:
            begin
                if (pick_done)
                begin
                    col_we       = 1'b1;
                    rvalid_next  = 1'b1;
                    rvertex_next = a_reg;
                    rcolor_next  = idx_reg;
                    state_next   = ST_IDLE;
                end
                else if (used_reg[idx_reg] && (int'(idx_reg) != MAX_COLOR))
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_reg        <= 1'b0;
            rvalid_reg      <= 1'b0;
            rvertex_reg     <= '0;
            rcolor_reg      <= '0;
            adj_row_vld_reg <= '0;
            col_vld_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            rvalid_reg  <= rvalid_next;
            rvertex_reg <= rvertex_next;
            rcolor_reg  <= rcolor_next;
            if (adj_we)
            begin
                adj_row_vld_reg[adj_waddr] <= 1'b1;
            end
            if (col_we)
            begin
                col_vld_reg[a_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        idx_reg   <= idx_next;
        idx_d_reg <= idx_d_next;
        used_reg  <= used_next;
    end

    // Adjacency memory port: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rd_reg     <= adj_mem[adj_raddr];
        adj_rd_vld_reg <= adj_row_vld_reg[adj_raddr];
    end

    // Color memory port: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[a_reg] <= idx_reg;
        end
        col_rd_reg     <= col_mem[col_raddr];
        col_rd_vld_reg <= col_vld_reg[col_raddr];
    end

endmodule

/* hdl/ffgc_checker.sv */
// Port-level checker for the first-fit graph coloring block, with its bind.
`include "assert_macros.svh"

module ffgc_checker
    import ffgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  logic               func,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [VERT_W-1:0]  vertex,
    input  logic [COLOR_W-1:0] color
);

    // A reported color is always a real color within range.
    `ASSERT_SAME(a_color_range, result_valid, (color != '0) && (int'(color) <= MAX_COLOR), "color out of range")

    // A color transfer keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_color_busy, item_valid && item_ready && (func == FUNC_COLOR), !item_ready, "ready after color transfer")

    // A new result only appears at the end of a busy stretch.
    `ASSERT_SAME(a_result_after_busy, $rose(result_valid), $past(!item_ready), "result without busy sequencer")

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(vertex) && $stable(color), "stalled result changed")

endmodule

bind first_fit_graph_coloring ffgc_checker u_ffgc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .vertex       (vertex),
    .color        (color)
);
